[design/u8u16_pkg.sv]
`default_nettype none

package u8u16_pkg;

  // Default depth of the queue between the decoder and the unit emitter.
  localparam int unsigned QueueDepthDef = 4;

  // UTF-16 and Unicode code point constants.
  localparam logic [15:0] SurrHighBase = 16'hD800;
  localparam logic [15:0] SurrLowBase  = 16'hDC00;
  localparam logic [20:0] PlaneBase    = 21'h010000;
  localparam logic [20:0] CodeLimit    = 21'h110000;

  // Number of code units that one decoded byte yields.
  typedef enum logic [1:0] {
    UnitsNone = 2'd0,
    UnitsOne  = 2'd1,
    UnitsTwo  = 2'd2
  } units_e;

  // One queue entry: the work that one input byte leaves for the back end.
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    units_e      n_units;
    logic        last;
  } u8u16_entry_t;

endpackage

`default_nettype wire

[design/u8u16_front.sv]
`default_nettype none

module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   in_byte_i,
  input  wire logic         in_last_i,
  output logic              push_valid_o,
  output u8u16_entry_t      push_entry_o,
  input  wire logic         push_ready_i
);

  logic [20:0] pcp_q, pcp_d;
  logic [1:0]  br_q, br_d;
  logic [20:0] cp;
  logic [20:0] cp_offs;
  logic        complete;
  logic        in_fire;
  u8u16_entry_t entry;

  assign in_ready_o = push_ready_i;
  assign in_fire    = in_valid_i && push_ready_i;

  always_comb begin
    pcp_d    = pcp_q;
    br_d     = br_q;
    complete = 1'b0;
    if (br_q != 2'd0) begin
      pcp_d    = {pcp_q[14:0], in_byte_i[5:0]};
      br_d     = br_q - 2'd1;
      complete = (br_q == 2'd1);
    end else if (!in_byte_i[7]) begin
      pcp_d    = {13'd0, in_byte_i};
      complete = 1'b1;
    end else if (in_byte_i[7:5] == 3'b110) begin
      pcp_d = {16'd0, in_byte_i[4:0]};
      br_d  = 2'd1;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      pcp_d = {17'd0, in_byte_i[3:0]};
      br_d  = 2'd2;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      pcp_d = {18'd0, in_byte_i[2:0]};
      br_d  = 2'd3;
    end

    // A string that ends inside a sequence is padded with zero bits.
    if (!complete && in_last_i && (br_d != 2'd0)) begin
      unique case (br_d)
        2'd1:    pcp_d = {pcp_d[14:0], 6'd0};
        2'd2:    pcp_d = {pcp_d[8:0], 12'd0};
        2'd3:    pcp_d = {pcp_d[2:0], 18'd0};
        default: pcp_d = pcp_d;
      endcase
      br_d     = 2'd0;
      complete = 1'b1;
    end

    cp = pcp_d;
    if (complete) begin
      pcp_d = '0;
    end
    if (in_last_i) begin
      pcp_d = '0;
      br_d  = 2'd0;
    end
  end

  assign cp_offs = cp - PlaneBase;

  always_comb begin
    entry.unit0   = '0;
    entry.unit1   = '0;
    entry.n_units = UnitsNone;
    entry.last    = in_last_i;
    if (complete) begin
      if (cp < PlaneBase) begin
        entry.unit0   = cp[15:0];
        entry.n_units = UnitsOne;
      end else if (cp < CodeLimit) begin
        entry.unit0   = SurrHighBase | {6'd0, cp_offs[19:10]};
        entry.unit1   = SurrLowBase | {6'd0, cp[9:0]};
        entry.n_units = UnitsTwo;
      end
    end
  end

  assign push_valid_o = in_fire && ((entry.n_units != UnitsNone) || in_last_i);
  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q <= '0;
      br_q  <= 2'd0;
    end else if (in_fire) begin
      pcp_q <= pcp_d;
      br_q  <= br_d;
    end
  end

endmodule

`default_nettype wire

[design/u8u16_queue.sv]
`default_nettype none

module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  input  wire u8u16_entry_t push_entry_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output u8u16_entry_t      pop_entry_o,
  input  wire logic         pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8u16_entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic push_fire, pop_fire;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = entries_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_fire) - CntW'(pop_fire);
    end
  end

endmodule

`default_nettype wire

[design/u8u16_back.sv]
`default_nettype none

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         head_valid_i,
  input  wire u8u16_entry_t head_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [15:0]       code_unit_o,
  output logic              unit_valid_o,
  output logic              run_last_o,
  output logic              string_end_o
);

  logic        out_valid_q, out_valid_d;
  logic        phase_q, phase_d;
  logic [15:0] code_unit_q, code_unit_d;
  logic        unit_valid_q, unit_valid_d;
  logic        run_last_q, run_last_d;
  logic        string_end_q, string_end_d;
  logic        load;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    phase_d      = phase_q;
    code_unit_d  = code_unit_q;
    unit_valid_d = unit_valid_q;
    run_last_d   = run_last_q;
    string_end_d = string_end_q;
    pop_o        = 1'b0;
    if (load) begin
      out_valid_d  = 1'b1;
      string_end_d = head_entry_i.last;
      unit_valid_d = (head_entry_i.n_units != UnitsNone);
      if (phase_q) begin
        code_unit_d = head_entry_i.unit1;
        run_last_d  = 1'b1;
        phase_d     = 1'b0;
        pop_o       = 1'b1;
      end else begin
        code_unit_d = head_entry_i.unit0;
        if (head_entry_i.n_units == UnitsTwo) begin
          run_last_d = 1'b0;
          phase_d    = 1'b1;
        end else begin
          run_last_d = 1'b1;
          pop_o      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_unit_q  <= code_unit_d;
    unit_valid_q <= unit_valid_d;
    run_last_q   <= run_last_d;
    string_end_q <= string_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_unit_o  = code_unit_q;
  assign unit_valid_o = unit_valid_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

  // The second half of a surrogate pair waits only on a two-unit head entry.
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_valid_i && (head_entry_i.n_units == UnitsTwo)))
    else $error("second unit pending without a two-unit head entry");

  // A bare end marker appears only on the final byte of a string.
  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !unit_valid_q) |-> (string_end_q && run_last_q))
    else $error("end marker without string end");

  // A result that is not the last of its byte is always followed by the low surrogate.
  a_pair_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !run_last_q) |-> phase_q)
    else $error("high surrogate shown without a pending low surrogate");

endmodule

`default_nettype wire

[design/utf8_to_utf16_transcoder_unit.sv]
`default_nettype none

// UTF-8 to UTF-16 transcoder. Bytes enter on the slave stream, one byte per request, with
// tlast on the final byte of a string; UTF-16 code units leave on the master stream. The
// lead byte sets the sequence length, the following bytes are taken as continuation bytes
// without checking and give their low six bits. Code points below 0x10000 give one unit,
// code points up to 0x10FFFF give a high then a low surrogate, larger values and invalid
// lead bytes give nothing. A string cut short inside a sequence is padded with zero bits.
// When the final byte of a string yields no unit, a bare end marker (unit flag low, code
// zero) is sent so that the string end is never lost. The input accepts one byte every
// cycle while the queue between the decoder and the unit emitter has room; the emitter
// sends one unit per cycle from its output register while the output stream is ready, so
// a four-byte sequence gives two units. A byte's entry is written to the queue when the
// byte is accepted and moves into the output register once it is at the head of the queue
// and that register is free. The queue depth (QueueDepth) sets how long the output side
// may stall before input requests are held off. There is no clearing pass after reset.
module utf8_to_utf16_transcoder_unit
  import u8u16_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream: tdata[7:0] = in_byte; tlast = last_byte.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tlast_i,
  // Master stream: tdata[15:0] = code_unit, tdata[16] = run_last, rest zero.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,
  // tuser[0] = unit_valid.
  output logic             m_axis_tuser_o,
  // tlast = string_end.
  output logic             m_axis_tlast_o
);

  u8u16_entry_t push_entry, head_entry;
  logic push_valid, push_ready;
  logic head_valid, pop;
  logic [15:0] code_unit;
  logic run_last;

  // The front end decodes each byte and leaves at most one entry per byte in the queue.
  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  // The queue decouples byte intake from unit delivery.
  u8u16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (head_valid),
    .pop_entry_o  (head_entry),
    .pop_i        (pop)
  );

  // The back end turns each entry into one or two results, one per cycle unless stalled.
  u8u16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .code_unit_o  (code_unit),
    .unit_valid_o (m_axis_tuser_o),
    .run_last_o   (run_last),
    .string_end_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, run_last, code_unit};

endmodule

`default_nettype wire
